### rtl/wrb_pkg.sv
// Package for the watermark ring buffer: sizes, operation and run-state codes,
// request/result structs. No dependencies.

package wrb_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int LVL_W        = 13;
  localparam int CMP_W        = (CNT_W > LVL_W) ? CNT_W : LVL_W;
  localparam int CFG_IDX_W    = 1;

  localparam logic [LVL_W-1:0] READY_LEVEL_RST  = LVL_W'((BUFFER_DEPTH * 90) / 100);
  localparam logic [LVL_W-1:0] RESUME_LEVEL_RST = LVL_W'((BUFFER_DEPTH * 80) / 100);

  localparam logic [CFG_IDX_W-1:0] CFG_READY_LEVEL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESUME_LEVEL = 1'b1;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_END   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_BUFFERING = 2'd1,
    MODE_SUSPENDED = 2'd2,
    MODE_STOPPING  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_in;
  } in_req_t;

  typedef struct packed {
    logic             op_accepted;
    logic [7:0]       data_out;
    logic             data_valid;
    logic [LVL_W-1:0] fill_level;
    logic [1:0]       run_state;
    logic             reader_blocked;
    logic             ready_event;
    logic             resume_event;
  } out_res_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

endpackage

### rtl/wrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module wrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/wrb_ctrl.sv
// Run-state control, pointers, fill count and watermark registers.
// Issues RAM requests and registers the status part of each result. Uses wrb_pkg.

module wrb_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  input  wrb_pkg::in_req_t               req,
  input  logic                           cfg_we,
  input  logic [wrb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wrb_pkg::LVL_W-1:0]      cfg_wdata,
  output wrb_pkg::ram_req_t              ram_req,
  output logic                           st_valid,
  output wrb_pkg::out_res_t              st
);
  import wrb_pkg::*;

  logic [PTR_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [PTR_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  mode_t            mode_r, mode_nxt;
  logic             waiting_r, waiting_nxt;
  logic [LVL_W-1:0] ready_lvl_r, resume_lvl_r;
  logic             st_valid_r;
  out_res_t         st_r, st_nxt;

  logic             acc, dvalid, rdy_ev, res_ev;
  logic [CNT_W-1:0] fill_inc, fill_dec;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    next_pos = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign fill_inc = fill_r + 1'b1;
  assign fill_dec = fill_r - 1'b1;

  always_comb begin
    rd_pos_nxt  = rd_pos_r;
    wr_pos_nxt  = wr_pos_r;
    fill_nxt    = fill_r;
    mode_nxt    = mode_r;
    waiting_nxt = waiting_r;
    acc         = 1'b0;
    dvalid      = 1'b0;
    rdy_ev      = 1'b0;
    res_ev      = 1'b0;
    ram_req     = '{we: 1'b0, waddr: wr_pos_r, wdata: req.data_in, re: 1'b0, raddr: rd_pos_r};

    if (req_valid) begin
      unique case (op_t'(req.operation))
        OP_PUSH: begin
          if (mode_r == MODE_STOPPING) begin
            rdy_ev      = waiting_r;
            mode_nxt    = MODE_STOPPED;
            waiting_nxt = 1'b0;
            fill_nxt    = '0;
            rd_pos_nxt  = '0;
            wr_pos_nxt  = '0;
          end else if (mode_r == MODE_BUFFERING) begin
            if (fill_r == CNT_W'(BUFFER_DEPTH)) begin
              mode_nxt = MODE_SUSPENDED;
            end else begin
              ram_req.we = 1'b1;
              wr_pos_nxt = next_pos(wr_pos_r);
              fill_nxt   = fill_inc;
              acc        = 1'b1;
              if (waiting_r && (CMP_W'(fill_inc) >= CMP_W'(ready_lvl_r))) begin
                waiting_nxt = 1'b0;
                rdy_ev      = 1'b1;
              end
            end
          end
        end
        OP_POP: begin
          if (fill_r == '0) begin
            if (mode_r == MODE_BUFFERING || mode_r == MODE_SUSPENDED) begin
              waiting_nxt = 1'b1;
            end
          end else if (!waiting_r) begin
            ram_req.re = 1'b1;
            dvalid     = 1'b1;
            rd_pos_nxt = next_pos(rd_pos_r);
            fill_nxt   = fill_dec;
            if (mode_r == MODE_SUSPENDED && (CMP_W'(fill_dec) < CMP_W'(resume_lvl_r))) begin
              mode_nxt = MODE_BUFFERING;
              res_ev   = 1'b1;
            end
          end
        end
        OP_START: begin
          if (mode_r == MODE_STOPPED) begin
            mode_nxt   = MODE_BUFFERING;
            fill_nxt   = '0;
            rd_pos_nxt = '0;
            wr_pos_nxt = '0;
            acc        = 1'b1;
          end
        end
        OP_STOP: begin
          if (mode_r == MODE_BUFFERING || mode_r == MODE_SUSPENDED) begin
            mode_nxt = MODE_STOPPING;
          end
        end
        OP_END: begin
          if (mode_r != MODE_STOPPED) begin
            rdy_ev      = waiting_r;
            mode_nxt    = MODE_STOPPED;
            waiting_nxt = 1'b0;
            fill_nxt    = '0;
            rd_pos_nxt  = '0;
            wr_pos_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
    end

    st_nxt.op_accepted    = acc;
    st_nxt.data_out       = '0;  // filled from RAM in the result stage
    st_nxt.data_valid     = dvalid;
    st_nxt.fill_level     = LVL_W'(fill_nxt);
    st_nxt.run_state      = mode_nxt;
    st_nxt.reader_blocked = waiting_nxt;
    st_nxt.ready_event    = rdy_ev;
    st_nxt.resume_event   = res_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r     <= '0;
      wr_pos_r     <= '0;
      fill_r       <= '0;
      mode_r       <= MODE_STOPPED;
      waiting_r    <= 1'b0;
      ready_lvl_r  <= READY_LEVEL_RST;
      resume_lvl_r <= RESUME_LEVEL_RST;
      st_valid_r   <= 1'b0;
    end else begin
      rd_pos_r   <= rd_pos_nxt;
      wr_pos_r   <= wr_pos_nxt;
      fill_r     <= fill_nxt;
      mode_r     <= mode_nxt;
      waiting_r  <= waiting_nxt;
      st_valid_r <= req_valid;
      if (cfg_we && cfg_idx == CFG_READY_LEVEL) begin
        ready_lvl_r <= cfg_wdata;
      end
      if (cfg_we && cfg_idx == CFG_RESUME_LEVEL) begin
        resume_lvl_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign st_valid = st_valid_r;
  assign st       = st_r;

  // Fill count never exceeds the buffer size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(BUFFER_DEPTH))
    else $error("fill count above buffer depth");

  // A stopped job never leaves a reader waiting.
  a_stopped_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_STOPPED |-> !waiting_r)
    else $error("reader waiting while stopped");

  // A RAM write adds exactly one byte to the fill count.
  a_write_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |=> fill_r == $past(fill_inc))
    else $error("fill count not advanced on write");

  // A RAM read takes exactly one byte from the fill count.
  a_read_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.re |=> fill_r == $past(fill_dec))
    else $error("fill count not reduced on read");

  // A request never writes and reads the byte store at once.
  a_read_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("write and read in one cycle");

endmodule

### rtl/watermark_ring_buffer.sv
// Top level of the watermark ring buffer: request port, result register,
// byte store RAM. Uses wrb_pkg, wrb_ctrl and wrb_ram.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+-----------------------------------
//  request  | start, busy, in_req          | taken when start && !busy
//  result   | out_valid, out_res           | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_idx, cfg_wdata   | written when cfg_we is high
//
// One request per cycle; busy is never raised.
// The result strobe follows the accepting edge through the control update and
// byte store read register, then the result register.
// Synchronous reset clears run state, pointers and fill count and reloads the
// watermark defaults; the byte store is not cleared and needs no sweep.
// The receiver cannot stall, so results leave at the request rate.

module watermark_ring_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  wrb_pkg::in_req_t              in_req,
  output logic                          out_valid,
  output wrb_pkg::out_res_t             out_res,
  input  logic                          cfg_we,
  input  logic [wrb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [wrb_pkg::LVL_W-1:0]     cfg_wdata
);
  import wrb_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       st_valid;
  out_res_t   st;
  logic       req_valid;
  logic       out_valid_r;
  out_res_t   out_res_r, out_res_nxt;

  assign busy      = 1'b0;
  assign req_valid = start && !busy;

  wrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (in_req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .ram_req   (ram_req),
    .st_valid  (st_valid),
    .st        (st)
  );

  wrb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_res_nxt          = st;
    out_res_nxt.data_out = st.data_valid ? ram_rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Each accepted request yields a result strobe after the control and result registers.
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |=> ##1 out_valid)
    else $error("result strobe missing");

  // No result strobe without a matching earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_valid, 2))
    else $error("result without request");

  // Data bytes are zero unless marked valid.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.data_valid |-> out_res.data_out == 8'd0)
    else $error("data byte without valid");

endmodule
